>>> design/tgr_pkg.sv
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared constants for the three-way gcd reduction block.
// ----------------------------------------------------------------------------
package tgr_pkg;

  // default width of each signed value of the triple
  localparam int unsigned VALUE_WIDTH_DEF = 16;

endpackage

>>> design/tgr_div.sv
// ----------------------------------------------------------------------------
// tgr_div
// Restoring unsigned divider, one quotient bit per cycle. Gives quotient and
// remainder together; shared for the gcd remainders and the exact divisions.
// ----------------------------------------------------------------------------
module tgr_div #(
  parameter int unsigned VALUE_WIDTH = tgr_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] quotient_o,
  output logic [VALUE_WIDTH-1:0] remainder_o
);
  import tgr_pkg::*;

  localparam int unsigned CntW = $clog2(VALUE_WIDTH + 1);

  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   done_q, done_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [VALUE_WIDTH-1:0] dsr_q, dsr_d;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   diff;
  logic                   fits;

  assign shifted = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign fits    = (shifted >= {1'b0, dsr_q});

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (cnt_q != '0) begin
      rem_d  = fits ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
      quo_d  = {quo_q[VALUE_WIDTH-2:0], fits};
      cnt_d  = cnt_q - CntW'(1);
      done_d = (cnt_q == CntW'(1));
    end else if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dsr_d = divisor_i;
      cnt_d = CntW'(VALUE_WIDTH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

>>> design/triple_gcd_reduce.sv
// ----------------------------------------------------------------------------
// triple_gcd_reduce
// Reduces a signed triple to lowest terms by its greatest common divisor.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the result is out. The result shows for one cycle with done_o and
// cannot be held off, so the receiver must take it then. All work runs on one
// restoring divider: first the Euclid remainder steps of two gcd passes, then
// three exact divisions. Each gcd pass takes at most about 1.44*VALUE_WIDTH
// remainder steps, far fewer on typical values. An all-zero triple finishes
// with all_zero_o set and zeros elsewhere.
module triple_gcd_reduce #(
  parameter int unsigned VALUE_WIDTH = tgr_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] index_h_i,
  input  logic signed [VALUE_WIDTH-1:0] index_k_i,
  input  logic signed [VALUE_WIDTH-1:0] index_l_i,
  output logic                          done_o,
  output logic signed [VALUE_WIDTH-1:0] reduced_h_o,
  output logic signed [VALUE_WIDTH-1:0] reduced_k_o,
  output logic signed [VALUE_WIDTH-1:0] reduced_l_o,
  output logic        [VALUE_WIDTH-1:0] common_factor_o,
  output logic                          all_zero_o
);
  import tgr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EUC,
    ST_EUC_WAIT,
    ST_RED_GO,
    ST_RED_WAIT
  } state_e;

  state_e                 state_q;
  logic                   pass_q;
  logic [1:0]             idx_q;
  logic [VALUE_WIDTH-1:0] a_q, b_q;
  logic [VALUE_WIDTH-1:0] mag_q [3];
  logic [2:0]             neg_q;
  logic [VALUE_WIDTH-1:0] res_q [3];
  logic [VALUE_WIDTH-1:0] factor_q;
  logic                   all_zero_q;
  logic                   done_q;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend, div_divisor;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo, div_rem;
  logic [VALUE_WIDTH-1:0] in_val [3];
  logic [VALUE_WIDTH-1:0] in_mag [3];

  assign in_val[0] = index_h_i;
  assign in_val[1] = index_k_i;
  assign in_val[2] = index_l_i;

  // magnitude of the most negative value wraps to 2^(W-1), still right unsigned
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_mag[i] = in_val[i][VALUE_WIDTH-1] ? (~in_val[i] + VALUE_WIDTH'(1)) : in_val[i];
    end
  end

  assign div_start    = (state_q == ST_RED_GO) || ((state_q == ST_EUC) && (b_q != '0));
  assign div_dividend = (state_q == ST_EUC) ? a_q : mag_q[idx_q];
  assign div_divisor  = (state_q == ST_EUC) ? b_q : a_q;

  tgr_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= 1'b0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            pass_q  <= 1'b0;
            state_q <= ST_EUC;
          end
        end
        ST_EUC: begin
          if (b_q == '0) begin
            if (!pass_q) begin
              pass_q <= 1'b1;
            end else if (a_q == '0) begin
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= '0;
              state_q <= ST_RED_GO;
            end
          end else begin
            state_q <= ST_EUC_WAIT;
          end
        end
        ST_EUC_WAIT: begin
          if (div_done) begin
            state_q <= ST_EUC;
          end
        end
        ST_RED_GO: begin
          state_q <= ST_RED_WAIT;
        end
        ST_RED_WAIT: begin
          if (div_done) begin
            if (idx_q == 2'd2) begin
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= ST_RED_GO;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= in_mag[i];
            neg_q[i] <= in_val[i][VALUE_WIDTH-1];
          end
          a_q <= in_mag[0];
          b_q <= in_mag[1];
        end
      end
      ST_EUC: begin
        if (b_q == '0) begin
          if (!pass_q) begin
            b_q <= mag_q[2];
          end else if (a_q == '0) begin
            for (int i = 0; i < 3; i++) begin
              res_q[i] <= '0;
            end
            factor_q   <= '0;
            all_zero_q <= 1'b1;
          end else begin
            factor_q   <= a_q;
            all_zero_q <= 1'b0;
          end
        end
      end
      ST_EUC_WAIT: begin
        if (div_done) begin
          a_q <= b_q;
          b_q <= div_rem;
        end
      end
      ST_RED_WAIT: begin
        if (div_done) begin
          res_q[idx_q] <= neg_q[idx_q] ? (~div_quo + VALUE_WIDTH'(1)) : div_quo;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign reduced_h_o     = res_q[0];
  assign reduced_k_o     = res_q[1];
  assign reduced_l_o     = res_q[2];
  assign common_factor_o = factor_q;
  assign all_zero_o      = all_zero_q;

  // divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_EUC_WAIT || state_q == ST_RED_WAIT))
    else $error("divider result with no waiting step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (all_zero_o == (common_factor_o == '0)))
    else $error("all_zero flag disagrees with factor");

  // a reduction start is never directly followed by a divider result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RED_GO) |=> !div_done)
    else $error("divider done right after start");

endmodule

>>> tb/triple_gcd_reduce_tb.sv
// ----------------------------------------------------------------------------
// triple_gcd_reduce_tb
// Self-checking bench for the three-way gcd reduction block.
// ----------------------------------------------------------------------------
// Triples come from a queue of pending items filled at time zero: a directed
// set of extremes and zero cases first, then random triples, most of them
// built around a known common factor. A clocked driver issues them with
// random gaps and bursts. A clocked monitor checks each done strobe against
// the oldest predicted reduction. A watchdog ends the run when nothing moves.
// ----------------------------------------------------------------------------
module triple_gcd_reduce_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W          = tgr_pkg::VALUE_WIDTH_DEF;
  localparam int unsigned N_RANDOM   = 1430;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned TAIL_WAIT  = 40;

  typedef logic [W-1:0] word_t;
  typedef logic [W:0]   mag_t;

  typedef struct packed {
    word_t h;
    word_t k;
    word_t l;
    word_t factor;
    logic  zero;
  } reduction_t;

  typedef struct {
    word_t       h;
    word_t       k;
    word_t       l;
    int unsigned gap;
    bit          drain;
  } triple_item_t;

  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start  = 1'b0;
  logic  busy;
  word_t index_h_i = '0;
  word_t index_k_i = '0;
  word_t index_l_i = '0;
  logic  done_o;
  logic  signed [W-1:0] reduced_h_o;
  logic  signed [W-1:0] reduced_k_o;
  logic  signed [W-1:0] reduced_l_o;
  word_t common_factor_o;
  logic  all_zero_o;

  triple_item_t pending_q[$];
  reduction_t   reduction_q[$];

  int unsigned n_sent     = 0;
  int unsigned n_checked  = 0;
  int unsigned n_errors   = 0;
  int unsigned n_zero     = 0;
  int unsigned n_factored = 0;
  int unsigned idle_cnt   = 0;

  triple_gcd_reduce #(
    .VALUE_WIDTH(W)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .index_h_i      (index_h_i),
    .index_k_i      (index_k_i),
    .index_l_i      (index_l_i),
    .done_o         (done_o),
    .reduced_h_o    (reduced_h_o),
    .reduced_k_o    (reduced_k_o),
    .reduced_l_o    (reduced_l_o),
    .common_factor_o(common_factor_o),
    .all_zero_o     (all_zero_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic mag_t euclid_gcd(mag_t a, mag_t b);
    mag_t r;
    while (b != '0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  function automatic reduction_t reduce_triple(word_t h, word_t k, word_t l);
    word_t      raw [3];
    mag_t       mag [3];
    mag_t       q;
    mag_t       g;
    word_t      red [3];
    reduction_t res;
    raw = '{h, k, l};
    for (int i = 0; i < 3; i++) begin
      // most negative value has magnitude 2^(W-1), hence the extra bit
      mag[i] = raw[i][W-1] ? (mag_t'(1) << W) - mag_t'(raw[i]) : mag_t'(raw[i]);
    end
    g = euclid_gcd(euclid_gcd(mag[0], mag[1]), mag[2]);
    res = '0;
    if (g == '0) begin
      res.zero = 1'b1;
      return res;
    end
    for (int i = 0; i < 3; i++) begin
      q      = mag[i] / g;
      red[i] = raw[i][W-1] ? word_t'(~q + 1'b1) : word_t'(q);
    end
    res.h      = red[0];
    res.k      = red[1];
    res.l      = red[2];
    res.factor = word_t'(g);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  function automatic word_t pick_extreme();
    int v [8] = '{-32768, -32767, -1, 0, 1, 32767, 16384, -16384};
    return word_t'(v[$urandom_range(0, 7)]);
  endfunction

  // multiple of g with random sign, magnitude at most 2^(W-1)
  function automatic word_t pick_multiple(int g);
    int m;
    int v;
    if ($urandom_range(0, 7) == 0) return '0;
    m = $urandom_range(0, (1 << (W - 1)) / g);
    v = m * g;
    if ($urandom_range(0, 1) == 1 || v > (1 << (W - 1)) - 1) v = -v;
    return word_t'(v);
  endfunction

  task automatic queue_triple(int h, int k, int l, int unsigned gap, bit drain);
    triple_item_t it;
    it.h     = word_t'(h);
    it.k     = word_t'(k);
    it.l     = word_t'(l);
    it.gap   = gap;
    it.drain = drain;
    pending_q.push_back(it);
  endtask

  task automatic queue_random_triples();
    triple_item_t it;
    int           g;
    int unsigned  kind;
    bit           burst;
    burst = 1'b0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        g    = $urandom_range(1, 1 << $urandom_range(0, W - 2));
        it.h = pick_multiple(g);
        it.k = pick_multiple(g);
        it.l = pick_multiple(g);
      end else if (kind < 80) begin
        it.h = word_t'($urandom);
        it.k = word_t'($urandom);
        it.l = word_t'($urandom);
      end else if (kind < 92) begin
        it.h = pick_extreme();
        it.k = pick_extreme();
        it.l = pick_extreme();
      end else if (kind < 95) begin
        it.h = '0;
        it.k = '0;
        it.l = '0;
      end else begin
        it.h = $urandom_range(0, 1) ? word_t'($urandom) : '0;
        it.k = $urandom_range(0, 1) ? word_t'($urandom) : '0;
        it.l = '0;
      end
      it.gap   = burst ? 0 : $urandom_range(0, 16);
      it.drain = ($urandom_range(0, 99) == 0);
      pending_q.push_back(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------
  triple_item_t cur_item;
  bit           have_item = 1'b0;
  int unsigned  gap_left  = 0;

  always @(posedge clk_i) begin
    logic start_nxt;
    if (rst_ni) begin
      start_nxt = start;
      if (start && !busy) begin
        reduction_q.push_back(reduce_triple(index_h_i, index_k_i, index_l_i));
        n_sent++;
        start_nxt = 1'b0;
        have_item = 1'b0;
      end
      if (!start_nxt) begin
        if (!have_item && pending_q.size() > 0) begin
          cur_item  = pending_q.pop_front();
          have_item = 1'b1;
          gap_left  = cur_item.gap;
        end
        if (have_item) begin
          if (gap_left > 0) begin
            gap_left--;
          // a drain item holds off until the block has nothing in flight
          end else if (!cur_item.drain || (reduction_q.size() == 0 && !done_o)) begin
            index_h_i <= cur_item.h;
            index_k_i <= cur_item.k;
            index_l_i <= cur_item.l;
            start_nxt = 1'b1;
          end
        end
      end
      start <= start_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string field, int got, int want);
    $display("ERROR result %0d: %s is %0d, expected %0d", n_checked, field, got, want);
    n_errors++;
  endtask

  always @(posedge clk_i) begin
    reduction_t want;
    if (rst_ni && done_o) begin
      if (reduction_q.size() == 0) begin
        $display("ERROR done strobe with no triple outstanding");
        n_errors++;
      end else begin
        want = reduction_q.pop_front();
        if (reduced_h_o !== want.h)
          report_mismatch("reduced_h", reduced_h_o, $signed(want.h));
        if (reduced_k_o !== want.k)
          report_mismatch("reduced_k", reduced_k_o, $signed(want.k));
        if (reduced_l_o !== want.l)
          report_mismatch("reduced_l", reduced_l_o, $signed(want.l));
        if (common_factor_o !== want.factor)
          report_mismatch("common_factor", common_factor_o, want.factor);
        if (all_zero_o !== want.zero)
          report_mismatch("all_zero", all_zero_o, want.zero);
        if (want.zero) n_zero++;
        if (want.factor > 1) n_factored++;
      end
      n_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        idle_cnt <= 0;
      end else if (idle_cnt >= IDLE_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    // directed: zero cases, most negative values, long Euclid chains
    queue_triple(0, 0, 0, 0, 1'b0);
    queue_triple(-32768, -32768, -32768, 0, 1'b0);
    queue_triple(-32768, 0, 0, 3, 1'b0);
    queue_triple(0, 0, -32768, 0, 1'b0);
    queue_triple(0, 5, 0, 0, 1'b0);
    queue_triple(0, 0, -1, 1, 1'b0);
    queue_triple(32767, 32767, 32767, 0, 1'b0);
    queue_triple(-1, -1, -1, 0, 1'b0);
    queue_triple(32767, -32768, 1, 2, 1'b0);
    queue_triple(-32768, 16384, 0, 0, 1'b0);
    queue_triple(-32768, -32768, 16384, 0, 1'b0);
    queue_triple(-16384, -16384, -16384, 0, 1'b1);
    queue_triple(28657, 17711, 10946, 0, 1'b0);
    queue_triple(-28657, -17711, 0, 0, 1'b0);
    queue_triple(12, 18, -30, 16, 1'b0);
    queue_triple(30000, -20000, 10000, 0, 1'b0);
    queue_triple(6, -9, 15, 0, 1'b0);
    queue_triple(-32767, 32767, 0, 0, 1'b0);
    queue_triple(21845, -10922, 32766, 0, 1'b0);
    queue_triple(0, 0, 0, 0, 1'b0);
    queue_random_triples();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() > 0 || have_item || start || n_checked != n_sent)
      @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("Reduced %0d triples: %0d all-zero, %0d with a common factor above one",
             n_sent, n_zero, n_factored);
    $display("Results checked: %0d, mismatches: %0d", n_checked, n_errors);
    if (n_errors == 0 && reduction_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (reduction_q.size() != 0)
        $display("ERROR %0d results never arrived", reduction_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
